// File: rtl/positional_list_insert_delete_top_assert.svh
// Assertion macros used by the checker of the positional list block.
`ifndef POSITIONAL_LIST_INSERT_DELETE_TOP_ASSERT_SVH
`define POSITIONAL_LIST_INSERT_DELETE_TOP_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define PLI_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("positional list check failed");

// A consequence that must hold in the cycle after its trigger.
`define PLI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("positional list check failed");

`endif

// File: rtl/pli_pkg.sv
// Types, codes and sizes shared by the positional list modules.
package pli_pkg;

    localparam int CAPACITY = 32;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int DATA_W   = 32;
    localparam int FUNC_W   = 3;
    localparam int POS_W    = 6;
    localparam int STAT_W   = 2;
    localparam int COUNT_W  = 6;
    localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    localparam logic [FUNC_W-1:0] F_INS_POS   = 3'd0;
    localparam logic [FUNC_W-1:0] F_INS_FRONT = 3'd1;
    localparam logic [FUNC_W-1:0] F_INS_BACK  = 3'd2;
    localparam logic [FUNC_W-1:0] F_DEL_POS   = 3'd3;
    localparam logic [FUNC_W-1:0] F_DEL_FRONT = 3'd4;
    localparam logic [FUNC_W-1:0] F_DEL_BACK  = 3'd5;
    localparam logic [FUNC_W-1:0] F_READ      = 3'd6;

    localparam logic [STAT_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd3;

    localparam logic [1:0] OP_HOLD = 2'd0;
    localparam logic [1:0] OP_INS  = 2'd1;
    localparam logic [1:0] OP_DEL  = 2'd2;

    typedef struct packed {
        logic [1:0]               op;
        logic [SLOT_W-1:0]        slot;
        logic signed [DATA_W-1:0] data;
    } cell_cmd_t;

endpackage

// File: rtl/pli_cell.sv
// One storage cell of the list chain: holds, takes its neighbor's word or the new word.
module pli_cell
    import pli_pkg::*;
(
    input  logic                     clk,
    input  cell_cmd_t                cmd,
    input  logic [SLOT_W-1:0]        cell_idx,
    input  logic signed [DATA_W-1:0] left_word,
    input  logic signed [DATA_W-1:0] right_word,
    output logic signed [DATA_W-1:0] cell_word,
    output logic signed [DATA_W-1:0] rd_word
);

    logic signed [DATA_W-1:0] word_reg;
    logic signed [DATA_W-1:0] word_next;

    always_comb
    begin
        word_next = word_reg;
        unique case (cmd.op)
            OP_INS:
            begin
                // Cells behind the slot move one place back.
                priority if (cell_idx > cmd.slot)
                begin
                    word_next = left_word;
                end
                else if (cell_idx == cmd.slot)
                begin
                    word_next = cmd.data;
                end
                else
                begin
                    word_next = word_reg;
                end
            end
            OP_DEL:
            begin
                if (cell_idx >= cmd.slot)
                begin
                    word_next = right_word;
                end
            end
            default:
            begin
                word_next = word_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign cell_word = word_reg;
    assign rd_word   = (cell_idx == cmd.slot) ? word_reg : '0;

endmodule

// File: rtl/pli_chain.sv
// Row of list cells linked to their neighbors, with the read-out of one selected cell.
module pli_chain
    import pli_pkg::*;
(
    input  logic                     clk,
    input  cell_cmd_t                cmd,
    output logic signed [DATA_W-1:0] sel_word
);

    logic signed [DATA_W-1:0] cell_words [CAPACITY];
    logic signed [DATA_W-1:0] rd_words   [CAPACITY];

    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        logic signed [DATA_W-1:0] left_w;
        logic signed [DATA_W-1:0] right_w;

        if (k == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_inner_l
            assign left_w = cell_words[k-1];
        end

        // The last cell empties into nothing; what it holds then is never read.
        if (k == CAPACITY - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_inner_r
            assign right_w = cell_words[k+1];
        end

        pli_cell u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .cell_idx   (SLOT_W'(k)),
            .left_word  (left_w),
            .right_word (right_w),
            .cell_word  (cell_words[k]),
            .rd_word    (rd_words[k])
        );
    end

    // Only the selected cell drives a nonzero word, so an OR gathers it.
    always_comb
    begin
        sel_word = '0;
        for (int k = 0; k < CAPACITY; k++)
        begin
            sel_word = sel_word | rd_words[k];
        end
    end

endmodule

// File: rtl/positional_list_insert_delete_top.sv
// Top level of the positional list store: request decode, entry count and result register.
//
//  channel | handshake            | fields
//  --------+----------------------+---------------------------------------
//  in      | in_valid / in_ready  | func, value, position
//  out     | out_valid / out_ready| status, entry_count, read_value
//
// A request is decoded and applied to the cell chain in the cycle it is taken, and its
// word appears in the result register at the next edge: one request per cycle unless the result stalls.
// All cells shift in that same cycle, so the rate does not depend on position or count.
// Reset clears the count and the result valid flag; the cells need no clearing pass.
// A new request is taken while the result is being taken, and held off while it stalls.
module positional_list_insert_delete_top
    import pli_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [FUNC_W-1:0]        func,
    input  logic signed [DATA_W-1:0] value,
    input  logic [POS_W-1:0]         position,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [STAT_W-1:0]        status,
    output logic [COUNT_W-1:0]       entry_count,
    output logic signed [DATA_W-1:0] read_value
);

    logic                     accept;
    cell_cmd_t                cmd;
    logic signed [DATA_W-1:0] sel_word;

    logic                     out_valid_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [STAT_W-1:0]        status_reg;
    logic [STAT_W-1:0]        status_next;
    logic signed [DATA_W-1:0] read_reg;
    logic signed [DATA_W-1:0] read_next;

    logic [CMP_W-1:0]         pos_ext;
    logic [CMP_W-1:0]         cnt_ext;
    logic                     pos_zero;
    logic                     full;
    logic                     empty;
    logic [SLOT_W-1:0]        pos_slot;
    logic [SLOT_W-1:0]        back_slot;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    assign pos_ext   = CMP_W'(position);
    assign cnt_ext   = CMP_W'(count_reg);
    assign pos_zero  = (position == '0);
    assign full      = (cnt_ext == CMP_W'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign pos_slot  = SLOT_W'(position - POS_W'(1));
    assign back_slot = SLOT_W'(count_reg);

    always_comb
    begin
        status_next = ST_DONE;
        count_next  = count_reg;
        read_next   = '0;
        cmd.op      = OP_HOLD;
        cmd.slot    = pos_slot;
        cmd.data    = value;
        unique case (func)
            F_INS_POS, F_INS_FRONT, F_INS_BACK:
            begin
                // A bad position is reported before a full store.
                priority if (func == F_INS_POS && (pos_zero || pos_ext > cnt_ext + 1'b1))
                begin
                    status_next = ST_BADPOS;
                end
                else if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    cmd.op     = OP_INS;
                    count_next = count_reg + 1'b1;
                    if (func == F_INS_FRONT)
                    begin
                        cmd.slot = '0;
                    end
                    else if (func == F_INS_BACK)
                    begin
                        cmd.slot = back_slot;
                    end
                end
            end
            F_DEL_POS:
            begin
                if (pos_zero || pos_ext > cnt_ext)
                begin
                    status_next = ST_BADPOS;
                end
                else
                begin
                    cmd.op     = OP_DEL;
                    count_next = count_reg - 1'b1;
                end
            end
            F_DEL_FRONT, F_DEL_BACK:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    cmd.op     = OP_DEL;
                    count_next = count_reg - 1'b1;
                    cmd.slot   = (func == F_DEL_FRONT) ? '0 : SLOT_W'(count_reg - 1'b1);
                end
            end
            F_READ:
            begin
                if (pos_zero || pos_ext > cnt_ext)
                begin
                    status_next = ST_BADPOS;
                end
                else
                begin
                    read_next = sel_word;
                end
            end
            default:
            begin
                status_next = ST_BADPOS;
            end
        endcase
        if (!accept)
        begin
            cmd.op = OP_HOLD;
        end
    end

    pli_chain u_chain (
        .clk      (clk),
        .cmd      (cmd),
        .sel_word (sel_word)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            if (accept)
            begin
                out_valid_reg <= 1'b1;
                count_reg     <= count_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            read_reg   <= read_next;
        end
    end

    // The count only moves with a new request, which also replaces the result.
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign entry_count = COUNT_W'(count_reg);
    assign read_value  = read_reg;

endmodule

// File: rtl/pli_checker.sv
// Port-level checks of the positional list store and their binding to the top level.
`include "positional_list_insert_delete_top_assert.svh"

module pli_checker
    import pli_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_ready,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [STAT_W-1:0]        status,
    input logic [COUNT_W-1:0]       entry_count,
    input logic signed [DATA_W-1:0] read_value
);

    `PLI_ASSERT_ALWAYS(a_count_bound, clk, rst_n,
        !out_valid || entry_count <= COUNT_W'(CAPACITY))
    `PLI_ASSERT_ALWAYS(a_read_only_done, clk, rst_n,
        !out_valid || read_value == '0 || status == ST_DONE)
    `PLI_ASSERT_ALWAYS(a_empty_count, clk, rst_n,
        !out_valid || status != ST_EMPTY || entry_count == '0)
    `PLI_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(status) && $stable(entry_count) && $stable(read_value))
    `PLI_ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid && !in_ready, in_valid)

endmodule

bind positional_list_insert_delete_top pli_checker u_pli_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .entry_count (entry_count),
    .read_value  (read_value)
);
